/* sv/text_console_char_writer_assert.svh */
// Assertion macros for the text console character writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw check failed");
`define TCW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw check failed");
`else
`define TCW_ASSERT_IMP(label, ante, cons)
`define TCW_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* sv/tcw_pkg.sv */
package tcw_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int M_TDATA_W    = 32;
    localparam int M_TUSER_W    = 2;
    localparam int OUT_PAD_W    = M_TDATA_W - CELL_INDEX_W - CHAR_W - ATTR_W;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CHAR_W-1:0] CURSOR_GLYPH = 8'hF9;
    localparam logic [CHAR_W-1:0] SPACE_GLYPH  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_VT      = 8'h0B;
    localparam logic [CHAR_W-1:0] CTRL_LAST    = 8'h1F;
    localparam logic [CHAR_W-1:0] CHAR_DEL     = 8'h7F;

    typedef enum logic [1:0] {
        GLYPH_CHAR,
        GLYPH_SPACE,
        GLYPH_CURSOR
    } glyph_sel_t;

    typedef struct packed {
        logic       load_char;
        logic       emit;
        glyph_sel_t glyph_sel;
        logic       with_attr;
        logic       last;
        logic       step;
        logic       new_line;
    } tcw_cmd_t;

    typedef struct packed {
        logic in_ignore;
        logic is_newline;
        logic is_tab;
        logic tab_fits;
        logic tab_last;
        logic out_free;
    } tcw_stat_t;

    function automatic logic is_ignored(input logic [CHAR_W-1:0] c);
        return (c <= CHAR_BS) || ((c >= CHAR_VT) && (c <= CTRL_LAST)) || (c == CHAR_DEL);
    endfunction

endpackage

/* sv/tcw_datapath.sv */
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [ATTR_W-1:0]    cfg_data,
    input  logic [CHAR_W-1:0]    s_tdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic [M_TUSER_W-1:0] m_tuser,
    input  tcw_cmd_t             cmd,
    output tcw_stat_t            stat
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS + 1);
    localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int SUM_W = $clog2(COLUMNS + TAB_STOP + 1);
    localparam int LIN_W = (ROW_W + 8 > CELL_INDEX_W) ? ROW_W + 8 : CELL_INDEX_W;

    logic [ATTR_W-1:0]       attr_reg;
    logic [CHAR_W-1:0]       char_reg;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next, row_adv;
    logic [PH_W-1:0]         phase_reg, phase_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CELL_INDEX_W-1:0] cell_reg, cell_next;
    logic [CHAR_W-1:0]       glyph_reg, glyph_next;
    logic [ATTR_W-1:0]       attr_value_reg, attr_value_next;
    logic                    attr_write_reg, attr_write_next;
    logic                    off_screen_reg, off_screen_next;
    logic                    last_reg;

    logic                    off;
    logic [CHAR_W-1:0]       glyph_sel_val;
    logic [LIN_W-1:0]        lin;
    logic [SUM_W-1:0]        tab_end;

    assign off     = (row_reg == ROW_W'(ROWS));
    assign lin     = LIN_W'(row_reg) * LIN_W'(COLUMNS) + LIN_W'(col_reg);
    assign tab_end = SUM_W'(col_reg) + SUM_W'(TAB_STOP) - SUM_W'(phase_reg);
    assign row_adv = off ? row_reg : row_reg + ROW_W'(1);

    assign stat.in_ignore  = is_ignored(s_tdata);
    assign stat.is_newline = (char_reg == CHAR_NEWLINE);
    assign stat.is_tab     = (char_reg == CHAR_TAB);
    assign stat.tab_fits   = (tab_end <= SUM_W'(COLUMNS));
    assign stat.tab_last   = (phase_reg == PH_W'(TAB_STOP - 1));
    assign stat.out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        unique case (cmd.glyph_sel)
            GLYPH_SPACE:  glyph_sel_val = SPACE_GLYPH;
            GLYPH_CURSOR: glyph_sel_val = CURSOR_GLYPH;
            default:      glyph_sel_val = char_reg;
        endcase
        if (off)
        begin
            cell_next       = '0;
            glyph_next      = '0;
            attr_value_next = '0;
            attr_write_next = 1'b0;
            off_screen_next = 1'b1;
        end
        else
        begin
            cell_next       = lin[CELL_INDEX_W-1:0];
            glyph_next      = glyph_sel_val;
            attr_value_next = cmd.with_attr ? attr_reg : '0;
            attr_write_next = cmd.with_attr;
            off_screen_next = 1'b0;
        end
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        priority if (cmd.new_line)
        begin
            col_next   = '0;
            phase_next = '0;
            row_next   = row_adv;
        end
        else if (cmd.step)
        begin
            if (col_reg == COL_W'(COLUMNS - 1))
            begin
                col_next   = '0;
                phase_next = '0;
                row_next   = row_adv;
            end
            else
            begin
                col_next   = col_reg + COL_W'(1);
                phase_next = stat.tab_last ? '0 : phase_reg + PH_W'(1);
            end
        end
    end

    always_comb
    begin
        priority if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= ATTR_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                attr_reg <= cfg_data;
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
            char_reg <= s_tdata;
        if (cmd.emit)
        begin
            cell_reg       <= cell_next;
            glyph_reg      <= glyph_next;
            attr_value_reg <= attr_value_next;
            attr_write_reg <= attr_write_next;
            off_screen_reg <= off_screen_next;
            last_reg       <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, attr_value_reg, glyph_reg, cell_reg};
    assign m_tuser  = {off_screen_reg, attr_write_reg};
    assign m_tlast  = last_reg;

endmodule

/* sv/tcw_controller.sv */
module tcw_controller
    import tcw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  tcw_stat_t stat,
    output tcw_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_TAB,
        ST_CURSOR
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_CURSOR) && stat.out_free);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd            = '0;
        cmd.glyph_sel  = GLYPH_CHAR;
        cmd.load_char  = accept && !stat.in_ignore;
        state_next     = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !stat.in_ignore)
                    state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    priority if (stat.is_newline || (stat.is_tab && !stat.tab_fits))
                    begin
                        cmd.glyph_sel = GLYPH_SPACE;
                        cmd.new_line  = 1'b1;
                        state_next    = ST_CURSOR;
                    end
                    else if (stat.is_tab)
                    begin
                        cmd.glyph_sel = GLYPH_SPACE;
                        cmd.with_attr = 1'b1;
                        cmd.step      = 1'b1;
                        state_next    = stat.tab_last ? ST_CURSOR : ST_TAB;
                    end
                    else
                    begin
                        cmd.with_attr = 1'b1;
                        cmd.step      = 1'b1;
                        state_next    = ST_CURSOR;
                    end
                end
            end
            ST_TAB:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.glyph_sel = GLYPH_SPACE;
                    cmd.with_attr = 1'b1;
                    cmd.step      = 1'b1;
                    state_next    = stat.tab_last ? ST_CURSOR : ST_TAB;
                end
            end
            ST_CURSOR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.glyph_sel = GLYPH_CURSOR;
                    cmd.with_attr = 1'b1;
                    cmd.last      = 1'b1;
                    state_next    = (accept && !stat.in_ignore) ? ST_FIRST : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/text_console_char_writer.sv */
// Teletype-style writer for a COLUMNS x ROWS text screen buffer.
// Input stream s_*: one character per transfer in s_tdata[7:0].
// Output stream m_*: one cell write per transfer; m_tlast marks the final
// write caused by a character. Configuration channel cfg_*: attribute byte,
// always ready; the user must write it only while the block is idle, and
// the block itself does not enforce this. A printable byte or newline makes
// two cell writes; a tab that fits makes N space writes (N up to TAB_STOP)
// and then the cursor write; an ignored control code makes none. The next
// character is taken in the cycle that issues the cursor write; the
// controller sequences one cell write per cycle, while the receiver takes
// them, through a single output register.
// First write: the transfer moves the controller to ST_FIRST, which loads m_*.
// Reset: cursor at column 0, row 0, attribute 0x07, output empty.
// Receiver stall: m_* holds its transfer; the write sequence waits until the
// output register is taken, and so does the input channel outside ST_IDLE.
`include "text_console_char_writer_assert.svh"

module text_console_char_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = COLUMNS_DEF,
    parameter int ROWS     = ROWS_DEF,
    parameter int TAB_STOP = TAB_STOP_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ATTR_W-1:0]    cfg_data,    // text_attr
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_W-1:0]    s_tdata,     // char_code
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // cell_index, glyph, attr_value, zero pad
    output logic                 m_tlast,     // last_write
    output logic [M_TUSER_W-1:0] m_tuser      // attr_write, off_screen
);

    tcw_cmd_t  cmd;
    tcw_stat_t stat;

    assign cfg_ready = 1'b1;

    tcw_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tcw_datapath
    #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

    `TCW_ASSERT_IMP(a_emit_free, cmd.emit, stat.out_free)
    `TCW_ASSERT_IMP(a_load_accept, cmd.load_char, s_tvalid && s_tready)
    `TCW_ASSERT_IMP(a_off_zero, m_tvalid && m_tuser[1], (m_tdata == '0) && !m_tuser[0])
    `TCW_ASSERT_NXT(a_last_shown, cmd.emit && cmd.last, m_tvalid && m_tlast)

endmodule
